### src/mams_pkg.sv
// Shared types and constants of the multi-axis move synchronizer.
package mams_pkg;

    localparam int SLOT_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam int REM_W = 51;
    localparam int LOW_W = 48;
    localparam int QUO_W = 48;
    localparam int DEN_W = 51;
    localparam int CNT_W = 6;

    localparam logic [19:0]      LEN_SCALE   = 20'd1000000;
    localparam logic [13:0]      SPEED_SCALE = 14'd15625;
    localparam logic [47:0]      TIME_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0]      FRAC_MAX    = 16'd58982;
    localparam logic [CNT_W-1:0] TGT_STEPS   = 6'd31;
    localparam logic [CNT_W-1:0] TIME_STEPS  = 6'd47;
    localparam logic [CNT_W-1:0] FRAC_STEPS  = 6'd15;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_HEXAPOD = 2'd1,
        MODE_VAXIS   = 2'd2,
        MODE_VPLANE  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE = 2'd0,
        CFG_X    = 2'd1,
        CFG_Y    = 2'd2,
        CFG_Z    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_TARGET = 2'd0,
        DIV_TIME   = 2'd1,
        DIV_FRAC   = 2'd2
    } div_op_t;

    typedef struct packed {
        logic    capture;
        logic    mult;
        logic    div_load;
        div_op_t div_op;
        logic    div_step;
        logic    tsave;
        logic    diff;
        logic    prod;
        logic    msave;
        logic    scan;
        logic    axis_clr;
        logic    axis_inc;
        logic    emit;
    } mams_cmd_t;

    typedef struct packed {
        logic last;
        logic axis_last;
        logic frac_div;
    } mams_stat_t;

endpackage

### src/mams_ifs.sv
// Item and result channel interfaces of the move synchronizer.
interface mams_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] strut_mm_q20;
    logic signed [31:0] position_counts;
    logic        [31:0] nm_per_count_q16;
    logic        [31:0] steps_per_count_q16;
    logic        [31:0] speed_limit;
    logic               last_axis;

    modport source (output valid, strut_mm_q20, position_counts, nm_per_count_q16,
                    steps_per_count_q16, speed_limit, last_axis, input ready);
    modport sink   (input valid, strut_mm_q20, position_counts, nm_per_count_q16,
                    steps_per_count_q16, speed_limit, last_axis, output ready);
endinterface

interface mams_result_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  axis_index;
    logic               axis_enabled;
    logic               send_move;
    logic signed [31:0] target_counts;
    logic        [15:0] velocity_fraction_q16;
    logic               last_result;

    modport source (output valid, axis_index, axis_enabled, send_move, target_counts,
                    velocity_fraction_q16, last_result, input ready);
    modport sink   (input valid, axis_index, axis_enabled, send_move, target_counts,
                    velocity_fraction_q16, last_result, output ready);
endinterface

### src/mams_datapath.sv
// Datapath: axis stores, multipliers, shared restoring divider and result register.
module mams_datapath #(
    parameter int AXIS_COUNT = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mams_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mams_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  mams_pkg::mams_cmd_t                 cmd,
    output mams_pkg::mams_stat_t                stat,
    input  logic [31:0]                         strut_mm_q20,
    input  logic [31:0]                         position_counts,
    input  logic [31:0]                         nm_per_count_q16,
    input  logic [31:0]                         steps_per_count_q16,
    input  logic [31:0]                         speed_limit,
    input  logic                                last_axis,
    output logic [2:0]                          axis_index,
    output logic                                axis_enabled,
    output logic                                send_move,
    output logic [31:0]                         target_counts,
    output logic [15:0]                         velocity_fraction_q16,
    output logic                                last_result
);
    localparam int IW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(AXIS_COUNT - 1);

    // Configuration registers.
    mams_pkg::mode_t   mode_reg;
    logic [2:0]        x_reg, y_reg, z_reg;

    // Captured item.
    logic              neg_reg, mag_zero_reg, last_reg;
    logic [31:0]       mag_reg, pos_reg, nm_reg, steps_reg, speed_reg;

    // Intermediate products.
    logic [51:0]       prod1_reg;
    logic [31:0]       tgt_reg, d_reg;
    logic [45:0]       den2_reg;
    logic [63:0]       p_reg;

    // Axis stores, written at the load slot and read at the current axis.
    logic [31:0]       target_store  [AXIS_COUNT];
    logic [31:0]       position_store[AXIS_COUNT];
    logic [47:0]       time_store    [AXIS_COUNT];
    logic [IW-1:0]     count_reg, axis_reg;

    // Longest time search.
    logic              found_reg;
    logic [47:0]       tmax_reg;

    // Divider.
    logic [mams_pkg::REM_W-1:0] div_rem_reg;
    logic [mams_pkg::LOW_W-1:0] div_low_reg;
    logic [mams_pkg::QUO_W-1:0] div_q_reg;
    logic [mams_pkg::DEN_W-1:0] div_den_reg;
    logic                       div_ovf_reg;

    logic [51:0]                ld_rem;
    logic [mams_pkg::LOW_W-1:0] ld_low;
    logic [mams_pkg::DEN_W-1:0] ld_den;
    logic [51:0]                t9;
    logic [51:0]                rem2, rem_sub;
    logic                       rem_ge;

    logic [2:0]        ax3;
    logic              on;
    logic [47:0]       t_sel;
    logic              q_over;
    logic [31:0]       tgt_calc;
    logic [32:0]       pos_diff;
    logic [31:0]       dist_abs;
    logic [15:0]       frac_q;

    assign ax3   = 3'(axis_reg);
    assign t_sel = time_store[axis_reg];

    always_comb
    begin
        unique case (mode_reg)
            mams_pkg::MODE_OFF:     on = 1'b0;
            mams_pkg::MODE_HEXAPOD: on = 1'b1;
            mams_pkg::MODE_VAXIS:   on = (ax3 == x_reg) || (ax3 == y_reg);
            mams_pkg::MODE_VPLANE:  on = (ax3 == x_reg) || (ax3 == y_reg) || (ax3 == z_reg);
            default:                on = 1'b0;
        endcase
    end

    assign stat.last      = last_reg;
    assign stat.axis_last = (axis_reg == LAST_IDX);
    assign stat.frac_div  = on && (tmax_reg != 48'd0);

    // Divider operand selection; the dividend is split into the initial
    // remainder and the bits still to be shifted in, MSB first.
    always_comb
    begin
        t9 = 52'(t_sel) + 52'({t_sel, 3'b000});
        unique case (cmd.div_op)
            mams_pkg::DIV_TARGET:
            begin
                ld_rem = 52'(prod1_reg[51:32]);
                ld_low = {prod1_reg[31:0], 16'd0};
                ld_den = 51'({nm_reg, 4'b0000});
            end
            mams_pkg::DIV_TIME:
            begin
                ld_rem = 52'(p_reg[63:45]);
                ld_low = {p_reg[44:0], 3'b000};
                ld_den = 51'(den2_reg);
            end
            mams_pkg::DIV_FRAC:
            begin
                ld_rem = 52'(t9[51:1]);
                ld_low = {t9[0], 47'd0};
                ld_den = 51'(tmax_reg) + 51'({tmax_reg, 2'b00});
            end
            default:
            begin
                ld_rem = '0;
                ld_low = '0;
                ld_den = '0;
            end
        endcase
    end

    assign rem2    = {div_rem_reg, div_low_reg[mams_pkg::LOW_W-1]};
    assign rem_ge  = rem2 >= {1'b0, div_den_reg};
    assign rem_sub = rem2 - {1'b0, div_den_reg};

    // Target from the quotient: rounds toward zero, saturates to 32 bits.
    assign q_over = div_ovf_reg || div_q_reg[31];
    always_comb
    begin
        if (mag_zero_reg)
        begin
            tgt_calc = 32'd0;
        end
        else if (neg_reg)
        begin
            tgt_calc = q_over ? 32'h8000_0000 : (32'd0 - div_q_reg[31:0]);
        end
        else
        begin
            tgt_calc = q_over ? 32'h7FFF_FFFF : div_q_reg[31:0];
        end
    end

    assign pos_diff = {pos_reg[31], pos_reg} - {tgt_reg[31], tgt_reg};
    assign dist_abs = pos_diff[32] ? 32'(33'd0 - pos_diff) : pos_diff[31:0];
    assign frac_q   = (div_q_reg[15:0] > mams_pkg::FRAC_MAX) ? mams_pkg::FRAC_MAX
                                                            : div_q_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= mams_pkg::MODE_OFF;
            x_reg     <= 3'd0;
            y_reg     <= 3'd1;
            z_reg     <= 3'd2;
            count_reg <= '0;
            axis_reg  <= '0;
            last_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (mams_pkg::cfg_idx_t'(cfg_index))
                    mams_pkg::CFG_MODE: mode_reg <= mams_pkg::mode_t'(cfg_data[1:0]);
                    mams_pkg::CFG_X:    x_reg    <= cfg_data;
                    mams_pkg::CFG_Y:    y_reg    <= cfg_data;
                    mams_pkg::CFG_Z:    z_reg    <= cfg_data;
                    default:            mode_reg <= mode_reg;
                endcase
            end
            if (cmd.capture)
            begin
                last_reg <= last_axis;
            end
            if (cmd.msave)
            begin
                found_reg <= 1'b0;
                if (last_reg)
                begin
                    count_reg <= '0;
                end
                else if (count_reg != LAST_IDX)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.scan && on && (!found_reg || (t_sel > tmax_reg)))
            begin
                found_reg <= 1'b1;
            end
            if (cmd.axis_clr)
            begin
                axis_reg <= '0;
            end
            else if (cmd.axis_inc)
            begin
                axis_reg <= axis_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            neg_reg      <= strut_mm_q20[31];
            mag_reg      <= strut_mm_q20[31] ? (32'd0 - strut_mm_q20) : strut_mm_q20;
            mag_zero_reg <= (strut_mm_q20 == 32'd0);
            pos_reg      <= position_counts;
            nm_reg       <= nm_per_count_q16;
            steps_reg    <= steps_per_count_q16;
            speed_reg    <= speed_limit;
        end
        if (cmd.mult)
        begin
            prod1_reg <= 52'(mag_reg) * 52'(mams_pkg::LEN_SCALE);
        end
        if (cmd.div_load)
        begin
            div_rem_reg <= ld_rem[mams_pkg::REM_W-1:0];
            div_low_reg <= ld_low;
            div_q_reg   <= '0;
            div_den_reg <= ld_den;
            div_ovf_reg <= ld_rem >= {1'b0, ld_den};
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= rem_ge ? rem_sub[mams_pkg::REM_W-1:0]
                                  : rem2[mams_pkg::REM_W-1:0];
            div_low_reg <= {div_low_reg[mams_pkg::LOW_W-2:0], 1'b0};
            div_q_reg   <= {div_q_reg[mams_pkg::QUO_W-2:0], rem_ge};
        end
        if (cmd.tsave)
        begin
            target_store[count_reg]   <= tgt_calc;
            position_store[count_reg] <= pos_reg;
            tgt_reg                   <= tgt_calc;
        end
        if (cmd.diff)
        begin
            d_reg    <= dist_abs;
            den2_reg <= 46'(speed_reg) * 46'(mams_pkg::SPEED_SCALE);
        end
        if (cmd.prod)
        begin
            p_reg <= 64'(d_reg) * 64'(steps_reg);
        end
        if (cmd.msave)
        begin
            time_store[count_reg] <= div_ovf_reg ? mams_pkg::TIME_MAX : div_q_reg;
            tmax_reg              <= 48'd0;
        end
        if (cmd.scan && on && (!found_reg || (t_sel > tmax_reg)))
        begin
            tmax_reg <= t_sel;
        end
        if (cmd.emit)
        begin
            axis_index            <= ax3;
            axis_enabled          <= on;
            send_move             <= on && (position_store[axis_reg] != target_store[axis_reg]);
            target_counts         <= on ? target_store[axis_reg] : 32'd0;
            velocity_fraction_q16 <= stat.frac_div ? frac_q : 16'd0;
            last_result           <= (axis_reg == LAST_IDX);
        end
    end

endmodule

### src/mams_ctrl.sv
// Controller: sequences per-item arithmetic, the longest-time scan and result output.
module mams_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  mams_pkg::mams_stat_t stat,
    output mams_pkg::mams_cmd_t  cmd
);
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00_0000_0000_0001,
        S_MULT  = 14'b00_0000_0000_0010,
        S_TLOAD = 14'b00_0000_0000_0100,
        S_TDIV  = 14'b00_0000_0000_1000,
        S_TSAVE = 14'b00_0000_0001_0000,
        S_DIFF  = 14'b00_0000_0010_0000,
        S_PROD  = 14'b00_0000_0100_0000,
        S_MLOAD = 14'b00_0000_1000_0000,
        S_MDIV  = 14'b00_0001_0000_0000,
        S_MSAVE = 14'b00_0010_0000_0000,
        S_SCAN  = 14'b00_0100_0000_0000,
        S_FLOAD = 14'b00_1000_0000_0000,
        S_FDIV  = 14'b01_0000_0000_0000,
        S_EMIT  = 14'b10_0000_0000_0000
    } state_t;

    state_t                       state_reg, state_next;
    logic [mams_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         wait_reg, wait_next;

    assign in_ready  = (state_reg == S_IDLE) && !wait_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        wait_next      = wait_reg;
        cmd            = '0;
        cmd.div_op     = mams_pkg::DIV_TARGET;
        if (wait_reg)
        begin
            // A result is waiting; the sequence resumes once it is taken.
            if (out_ready)
            begin
                out_valid_next = 1'b0;
                wait_next      = 1'b0;
                if (stat.axis_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.axis_inc = 1'b1;
                    state_next   = S_FLOAD;
                end
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_MULT;
                    end
                end
                S_MULT:
                begin
                    cmd.mult   = 1'b1;
                    state_next = S_TLOAD;
                end
                S_TLOAD:
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_op   = mams_pkg::DIV_TARGET;
                    cnt_next     = mams_pkg::TGT_STEPS;
                    state_next   = S_TDIV;
                end
                S_TDIV:
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = S_TSAVE;
                    end
                end
                S_TSAVE:
                begin
                    cmd.tsave  = 1'b1;
                    state_next = S_DIFF;
                end
                S_DIFF:
                begin
                    cmd.diff   = 1'b1;
                    state_next = S_PROD;
                end
                S_PROD:
                begin
                    cmd.prod   = 1'b1;
                    state_next = S_MLOAD;
                end
                S_MLOAD:
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_op   = mams_pkg::DIV_TIME;
                    cnt_next     = mams_pkg::TIME_STEPS;
                    state_next   = S_MDIV;
                end
                S_MDIV:
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = S_MSAVE;
                    end
                end
                S_MSAVE:
                begin
                    cmd.msave    = 1'b1;
                    cmd.axis_clr = 1'b1;
                    state_next   = stat.last ? S_SCAN : S_IDLE;
                end
                S_SCAN:
                begin
                    cmd.scan = 1'b1;
                    if (stat.axis_last)
                    begin
                        cmd.axis_clr = 1'b1;
                        state_next   = S_FLOAD;
                    end
                    else
                    begin
                        cmd.axis_inc = 1'b1;
                    end
                end
                S_FLOAD:
                begin
                    if (stat.frac_div)
                    begin
                        cmd.div_load = 1'b1;
                        cmd.div_op   = mams_pkg::DIV_FRAC;
                        cnt_next     = mams_pkg::FRAC_STEPS;
                        state_next   = S_FDIV;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                S_FDIV:
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    wait_next      = 1'b1;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            wait_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            wait_reg      <= wait_next;
        end
    end

endmodule

### src/multi_axis_move_synchronizer.sv
// Top level of the multi-axis move synchronizer.
// An item is taken in IDLE; its target is stored at TSAVE and its move time at MSAVE.
// No new item is taken until the last one is through; the shared divider runs 32 then 48 steps per item.
// The last_axis item then scans every stored axis, then per axis loads, divides out the fraction in
// 16 steps where it is needed, and emits before its result is offered, plus the wait for the sink.
// Reset (rst_n, asynchronous, active low) clears the controller, counters, configuration and flags.
module multi_axis_move_synchronizer #(
    parameter int AXIS_COUNT = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mams_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mams_pkg::CFG_DATA_W-1:0]   cfg_data,
    mams_item_if.sink                         items,
    mams_result_if.source                     results
);
    // The controller walks each item through target division, distance and
    // product, then the move-time division. On the last item it scans the
    // stored times for the longest among the enabled axes, then for every
    // axis offers one result item, dividing out the velocity fraction for an enabled axis with a nonzero longest time.
    // Only one item is in work at a time; no item is taken while a result
    // item waits in the output register.
    mams_pkg::mams_cmd_t  cmd;
    mams_pkg::mams_stat_t stat;

    mams_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the per-axis stores and the single restoring
    // divider that all three divisions share, one quotient bit per cycle.
    mams_datapath #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .cmd                   (cmd),
        .stat                  (stat),
        .strut_mm_q20          (items.strut_mm_q20),
        .position_counts       (items.position_counts),
        .nm_per_count_q16      (items.nm_per_count_q16),
        .steps_per_count_q16   (items.steps_per_count_q16),
        .speed_limit           (items.speed_limit),
        .last_axis             (items.last_axis),
        .axis_index            (results.axis_index),
        .axis_enabled          (results.axis_enabled),
        .send_move             (results.send_move),
        .target_counts         (results.target_counts),
        .velocity_fraction_q16 (results.velocity_fraction_q16),
        .last_result           (results.last_result)
    );

endmodule

### src/mams_checker.sv
// Port-level assertions for the move synchronizer, bound to the top level.
module mams_checker #(
    parameter int AXIS_COUNT = 6
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_index,
    input logic        out_enabled,
    input logic        out_send,
    input logic [31:0] out_target,
    input logic [15:0] out_frac,
    input logic        out_last
);
    // A pending result stays offered until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result item dropped before it was taken");

    // No new item is taken while a result item is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item accepted while a result item is pending");

    // The final result of a group describes the highest axis.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |-> (out_index == 3'(AXIS_COUNT - 1)))
        else $error("final result on the wrong axis");

    // A disabled axis reports no move, no target and no velocity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_enabled) |-> (!out_send && (out_target == 32'd0)
                                         && (out_frac == 16'd0)))
        else $error("disabled axis carries move data");

    // The velocity fraction never exceeds 0.9.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_frac <= 16'd58982))
        else $error("velocity fraction above 0.9");

endmodule

bind multi_axis_move_synchronizer mams_checker #(
    .AXIS_COUNT (AXIS_COUNT)
) u_mams_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (items.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_index   (results.axis_index),
    .out_enabled (results.axis_enabled),
    .out_send    (results.send_move),
    .out_target  (results.target_counts),
    .out_frac    (results.velocity_fraction_q16),
    .out_last    (results.last_result)
);
